[rtl/pfdm_pkg.sv]
// Package with shared types and constants for the PWM frequency and duty meter.
`timescale 1ns / 1ps

package pfdm_pkg;

    localparam int CAP_W    = 16;
    localparam int EXT_W    = 32;
    localparam int FREQ_W   = 28;
    localparam int DUTY_W   = 7;
    localparam int PRESC_W  = 16;
    localparam int PROD_W   = 39;
    localparam int DIVR_W   = 49;
    localparam int STEP_W   = 5;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;

    localparam logic [1:0] KIND_PERIOD = 2'd0;
    localparam logic [1:0] KIND_WIDTH  = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;
    localparam logic [1:0] KIND_ACK    = 2'd3;

    localparam logic CFG_CLOCK_HZ  = 1'b0;
    localparam logic CFG_PRESCALER = 1'b1;

    localparam logic [FREQ_W-1:0] CLOCK_HZ_RESET = 28'd36000000;
    localparam logic [DUTY_W-1:0] DUTY_FULL      = 7'd100;
    localparam logic [STEP_W-1:0] DUTY_STEPS     = 5'd7;
    localparam logic [STEP_W-1:0] FREQ_STEPS     = 5'd28;

    typedef enum logic [2:0] {
        OP_PERIOD,
        OP_PERIOD_ZERO,
        OP_WIDTH,
        OP_TICK,
        OP_ACK
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [EXT_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic              echo_valid;
        logic              echo_level;
        logic              report_valid;
        logic [FREQ_W-1:0] frequency_hz;
        logic [DUTY_W-1:0] duty_percent;
    } t_result;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIVR_W-1:0] rem_init;
        logic [FREQ_W-1:0] num;
        logic [DIVR_W-1:0] divisor;
    } t_div_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DUTY,
        ST_DUTY_WAIT,
        ST_FREQ,
        ST_FREQ_WAIT,
        ST_EMIT
    } t_state;

endpackage

[rtl/pwm_frequency_duty_meter_top.sv]
// Top level of the PWM frequency and duty meter.
//
//  Channel   Direction  Handshake              Payload
//  event     in         push / full            i_kind, i_capture_value
//  result    out        empty / pop            o_echo_valid, o_echo_level, o_report_valid,
//                                              o_frequency_hz, o_duty_percent
//  config    in         i_cfg_we (no wait)     i_cfg_index, i_cfg_data
//
// Width captures, overflow ticks, acknowledges and zero periods are handled in the idle state.
// A nonzero period capture runs through a multiply state, a 7-step duty division and a
// 28-step frequency division on the one shared restoring divider, plus sequencing states;
// when the duty saturates the duty division is skipped.
// Events are taken into a four-entry queue while the engine works or a result waits.
// Synchronous active-low reset; no clearing pass is needed after reset.
`timescale 1ns / 1ps

module pwm_frequency_duty_meter_top #(
    parameter int OVERFLOW_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_kind,
    input  logic [pfdm_pkg::CAP_W-1:0]    i_capture_value,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_echo_valid,
    output logic                          o_echo_level,
    output logic                          o_report_valid,
    output logic [pfdm_pkg::FREQ_W-1:0]   o_frequency_hz,
    output logic [pfdm_pkg::DUTY_W-1:0]   o_duty_percent,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [pfdm_pkg::FREQ_W-1:0]   i_cfg_data
);

    logic                          q_wr;
    logic                          q_rd;
    logic                          q_full;
    logic                          q_empty;
    pfdm_pkg::t_cmd                q_wr_cmd;
    pfdm_pkg::t_cmd                q_rd_cmd;
    pfdm_pkg::t_div_req            div_req;
    logic                          div_busy;
    logic                          div_done;
    logic [pfdm_pkg::FREQ_W-1:0]   div_quot;
    pfdm_pkg::t_result             result;

    pfdm_front #(
        .OVERFLOW_BITS (OVERFLOW_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_kind          (i_kind),
        .i_capture_value (i_capture_value),
        .i_q_full        (q_full),
        .o_q_wr          (q_wr),
        .o_q_cmd         (q_wr_cmd),
        .o_full          (full)
    );

    pfdm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_cmd   (q_wr_cmd),
        .i_rd    (q_rd),
        .o_cmd   (q_rd_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    pfdm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    pfdm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_cmd     (q_rd_cmd),
        .i_q_empty   (q_empty),
        .o_q_rd      (q_rd),
        .o_div_req   (div_req),
        .i_div_done  (div_done),
        .i_div_quot  (div_quot),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_echo_valid   = result.echo_valid;
    assign o_echo_level   = result.echo_level;
    assign o_report_valid = result.report_valid;
    assign o_frequency_hz = result.frequency_hz;
    assign o_duty_percent = result.duty_percent;

    // The engine must never restart the divider in the middle of a division.
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

    a_div_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> !div_busy)
        else $error("divider done while still busy");

    a_echo_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_echo_level) |-> o_echo_valid)
        else $error("echo level without echo");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_duty_percent <= pfdm_pkg::DUTY_FULL))
        else $error("duty above full scale");

endmodule

[rtl/pfdm_front.sv]
// Front end: accepts timer events, counts overflows and extends captures.
`timescale 1ns / 1ps

module pfdm_front #(
    parameter int OVERFLOW_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [1:0]                   i_kind,
    input  logic [pfdm_pkg::CAP_W-1:0]   i_capture_value,
    input  logic                         i_q_full,
    output logic                         o_q_wr,
    output pfdm_pkg::t_cmd               o_q_cmd,
    output logic                         o_full
);

    localparam logic [OVERFLOW_BITS-1:0] OVF_ONE = OVERFLOW_BITS'(1);

    logic [OVERFLOW_BITS-1:0]     r_ovf;
    logic [OVERFLOW_BITS-1:0]     n_ovf;
    logic [pfdm_pkg::CAP_W-1:0]   w_ovf_ext;
    logic                         w_accept;

    assign o_full   = i_q_full;
    assign w_accept = i_push && !i_q_full;
    assign o_q_wr   = w_accept;

    always_comb begin
        w_ovf_ext = '0;
        w_ovf_ext[OVERFLOW_BITS-1:0] = r_ovf;
    end

    always_comb begin
        o_q_cmd.value = {w_ovf_ext, i_capture_value};
        case (i_kind)
            pfdm_pkg::KIND_PERIOD: begin
                // An extended period of zero skips the measurement entirely.
                if ((i_capture_value == '0) && (r_ovf == '0)) begin
                    o_q_cmd.op = pfdm_pkg::OP_PERIOD_ZERO;
                end else begin
                    o_q_cmd.op = pfdm_pkg::OP_PERIOD;
                end
            end
            pfdm_pkg::KIND_WIDTH: o_q_cmd.op = pfdm_pkg::OP_WIDTH;
            pfdm_pkg::KIND_TICK:  o_q_cmd.op = pfdm_pkg::OP_TICK;
            default:              o_q_cmd.op = pfdm_pkg::OP_ACK;
        endcase
    end

    always_comb begin
        n_ovf = r_ovf;
        if (w_accept) begin
            if (i_kind == pfdm_pkg::KIND_PERIOD) begin
                n_ovf = '0;
            end else if (i_kind == pfdm_pkg::KIND_TICK) begin
                n_ovf = r_ovf + OVF_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= '0;
        end else begin
            r_ovf <= n_ovf;
        end
    end

endmodule

[rtl/pfdm_fifo.sv]
// Short command queue between the front end and the measurement engine.
`timescale 1ns / 1ps

module pfdm_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  pfdm_pkg::t_cmd   i_cmd,
    input  logic             i_rd,
    output pfdm_pkg::t_cmd   o_cmd,
    output logic             o_empty,
    output logic             o_full
);

    pfdm_pkg::t_cmd                r_mem [pfdm_pkg::QDEPTH];
    logic [pfdm_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [pfdm_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [pfdm_pkg::QPTR_W:0]     r_count;
    logic                          w_do_wr;
    logic                          w_do_rd;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (pfdm_pkg::QPTR_W + 1)'(pfdm_pkg::QDEPTH));
    assign w_do_wr = i_wr && !o_full;
    assign w_do_rd = i_rd && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_wr && !w_do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_rd && !w_do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/pfdm_div.sv]
// Restoring divider, one quotient bit per cycle, shared by duty and frequency.
`timescale 1ns / 1ps

module pfdm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfdm_pkg::t_div_req            i_req,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [pfdm_pkg::FREQ_W-1:0]   o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [pfdm_pkg::STEP_W-1:0]   r_cnt;
    logic [pfdm_pkg::DIVR_W-1:0]   r_rem;
    logic [pfdm_pkg::FREQ_W-1:0]   r_num;
    logic [pfdm_pkg::DIVR_W-1:0]   r_div;
    logic [pfdm_pkg::FREQ_W-1:0]   r_q;
    logic [pfdm_pkg::DIVR_W:0]     w_trial;
    logic [pfdm_pkg::DIVR_W:0]     w_diff;
    logic                          w_ge;

    // The partial remainder stays below the divisor, so the shifted trial
    // value needs only one bit more than the divisor.
    assign w_trial = {r_rem, r_num[pfdm_pkg::FREQ_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem_init;
            r_num <= i_req.num;
            r_div <= i_req.divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[pfdm_pkg::DIVR_W-1:0] : w_trial[pfdm_pkg::DIVR_W-1:0];
            r_num <= {r_num[pfdm_pkg::FREQ_W-2:0], 1'b0};
            r_q   <= {r_q[pfdm_pkg::FREQ_W-2:0], w_ge};
        end
    end

endmodule

[rtl/pfdm_back.sv]
// Measurement engine: executes queued events, sequences the divisions, holds the result.
`timescale 1ns / 1ps

module pfdm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [pfdm_pkg::FREQ_W-1:0]   i_cfg_data,
    input  pfdm_pkg::t_cmd                i_q_cmd,
    input  logic                          i_q_empty,
    output logic                          o_q_rd,
    output pfdm_pkg::t_div_req            o_div_req,
    input  logic                          i_div_done,
    input  logic [pfdm_pkg::FREQ_W-1:0]   i_div_quot,
    input  logic                          i_pop,
    output logic                          o_empty,
    output pfdm_pkg::t_result             o_result
);

    pfdm_pkg::t_state               r_state;
    pfdm_pkg::t_state               n_state;

    logic [pfdm_pkg::FREQ_W-1:0]    r_clock_hz;
    logic [pfdm_pkg::PRESC_W-1:0]   r_presc;
    logic [pfdm_pkg::EXT_W-1:0]     r_width;
    logic [pfdm_pkg::FREQ_W-1:0]    r_freq_now;
    logic [pfdm_pkg::DUTY_W-1:0]    r_duty_now;
    logic [pfdm_pkg::FREQ_W-1:0]    r_last_freq;
    logic [pfdm_pkg::DUTY_W-1:0]    r_last_duty;
    logic                           r_report_sent;
    logic                           r_out_valid;

    logic [pfdm_pkg::EXT_W-1:0]     r_period;
    logic                           r_echo;
    logic [pfdm_pkg::PROD_W-1:0]    r_prod;
    logic [pfdm_pkg::DIVR_W-1:0]    r_divisor;
    logic                           r_sat;
    logic [pfdm_pkg::DUTY_W-1:0]    r_duty_new;
    logic [pfdm_pkg::FREQ_W-1:0]    r_freq_new;
    pfdm_pkg::t_result              r_out;

    logic                           w_out_free;
    logic                           w_simple;
    logic                           w_start_period;
    logic                           w_latch_duty;
    logic                           w_latch_freq;
    logic                           w_emit;
    logic                           w_report;
    logic [pfdm_pkg::PROD_W-1:0]    w_prod;
    logic [pfdm_pkg::PRESC_W:0]     w_presc_p1;
    logic [pfdm_pkg::DIVR_W-1:0]    w_divf;

    assign w_out_free = !r_out_valid || i_pop;
    assign w_report   = (r_freq_new != r_last_freq) || (r_duty_new != r_last_duty);
    assign w_prod     = {7'd0, r_width} * {32'd0, pfdm_pkg::DUTY_FULL};
    assign w_presc_p1 = {1'b0, r_presc} + 17'd1;
    assign w_divf     = {17'd0, r_period} * {32'd0, w_presc_p1};

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pfdm_pkg::ST_IDLE: begin
                if (!i_q_empty && (i_q_cmd.op == pfdm_pkg::OP_PERIOD)) begin
                    n_state = pfdm_pkg::ST_MUL;
                end
            end
            pfdm_pkg::ST_MUL:  n_state = pfdm_pkg::ST_DUTY;
            pfdm_pkg::ST_DUTY: n_state = r_sat ? pfdm_pkg::ST_FREQ : pfdm_pkg::ST_DUTY_WAIT;
            pfdm_pkg::ST_DUTY_WAIT: begin
                if (i_div_done) begin
                    n_state = pfdm_pkg::ST_FREQ;
                end
            end
            pfdm_pkg::ST_FREQ: n_state = pfdm_pkg::ST_FREQ_WAIT;
            pfdm_pkg::ST_FREQ_WAIT: begin
                if (i_div_done) begin
                    n_state = pfdm_pkg::ST_EMIT;
                end
            end
            pfdm_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = pfdm_pkg::ST_IDLE;
                end
            end
            default: n_state = pfdm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_rd         = 1'b0;
        w_simple       = 1'b0;
        w_start_period = 1'b0;
        w_latch_duty   = 1'b0;
        w_latch_freq   = 1'b0;
        w_emit         = 1'b0;
        o_div_req      = '0;
        case (r_state)
            pfdm_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_cmd.op == pfdm_pkg::OP_PERIOD) begin
                        o_q_rd         = 1'b1;
                        w_start_period = 1'b1;
                    end else if (w_out_free) begin
                        o_q_rd   = 1'b1;
                        w_simple = 1'b1;
                    end
                end
            end
            pfdm_pkg::ST_DUTY: begin
                // Width below period keeps the quotient under 128, so seven
                // steps suffice once the top bits are preloaded as remainder.
                if (!r_sat) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.steps    = pfdm_pkg::DUTY_STEPS;
                    o_div_req.rem_init = {17'd0, r_prod[pfdm_pkg::PROD_W-1:7]};
                    o_div_req.num      = {r_prod[6:0], 21'd0};
                    o_div_req.divisor  = {17'd0, r_period};
                end
            end
            pfdm_pkg::ST_DUTY_WAIT: w_latch_duty = i_div_done;
            pfdm_pkg::ST_FREQ: begin
                o_div_req.start    = 1'b1;
                o_div_req.steps    = pfdm_pkg::FREQ_STEPS;
                o_div_req.rem_init = '0;
                o_div_req.num      = r_clock_hz;
                o_div_req.divisor  = r_divisor;
            end
            pfdm_pkg::ST_FREQ_WAIT: w_latch_freq = i_div_done;
            pfdm_pkg::ST_EMIT: w_emit = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= pfdm_pkg::ST_IDLE;
            r_clock_hz    <= pfdm_pkg::CLOCK_HZ_RESET;
            r_presc       <= '0;
            r_width       <= '0;
            r_freq_now    <= '0;
            r_duty_now    <= '0;
            r_last_freq   <= '0;
            r_last_duty   <= '0;
            r_report_sent <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == pfdm_pkg::CFG_CLOCK_HZ) begin
                    r_clock_hz <= i_cfg_data;
                end else begin
                    r_presc <= i_cfg_data[pfdm_pkg::PRESC_W-1:0];
                end
            end
            if (w_simple) begin
                if (i_q_cmd.op == pfdm_pkg::OP_WIDTH) begin
                    r_width <= i_q_cmd.value;
                end
                if (i_q_cmd.op == pfdm_pkg::OP_ACK) begin
                    r_last_freq   <= r_freq_now;
                    r_last_duty   <= r_duty_now;
                    r_report_sent <= 1'b1;
                end
            end
            if (w_emit) begin
                r_freq_now <= r_freq_new;
                r_duty_now <= r_duty_new;
                r_width    <= '0;
                if (w_report) begin
                    r_report_sent <= 1'b0;
                end
            end
            if (w_simple || w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start_period) begin
            r_period <= i_q_cmd.value;
            r_echo   <= r_report_sent;
        end
        if (r_state == pfdm_pkg::ST_MUL) begin
            r_prod    <= w_prod;
            r_divisor <= w_divf;
            r_sat     <= r_width >= r_period;
        end
        if ((r_state == pfdm_pkg::ST_DUTY) && r_sat) begin
            r_duty_new <= pfdm_pkg::DUTY_FULL;
        end else if (w_latch_duty) begin
            r_duty_new <= i_div_quot[pfdm_pkg::DUTY_W-1:0];
        end
        if (w_latch_freq) begin
            r_freq_new <= i_div_quot;
        end
        if (w_emit) begin
            r_out.echo_valid   <= r_echo;
            r_out.echo_level   <= r_echo;
            r_out.report_valid <= w_report;
            r_out.frequency_hz <= r_freq_new;
            r_out.duty_percent <= r_duty_new;
        end else if (w_simple) begin
            r_out.report_valid <= 1'b0;
            r_out.frequency_hz <= r_freq_now;
            r_out.duty_percent <= r_duty_now;
            case (i_q_cmd.op)
                pfdm_pkg::OP_WIDTH: begin
                    r_out.echo_valid <= r_report_sent;
                    r_out.echo_level <= 1'b0;
                end
                pfdm_pkg::OP_PERIOD_ZERO: begin
                    r_out.echo_valid <= r_report_sent;
                    r_out.echo_level <= r_report_sent;
                end
                default: begin
                    r_out.echo_valid <= 1'b0;
                    r_out.echo_level <= 1'b0;
                end
            endcase
        end
    end

endmodule
